FILE: hw/rtl/rbec_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rbec_pkg
// Shared constants and types for the ray box entry clip block.
// ---------------------------------------------------------------------------
package rbec_pkg;

    localparam int CoordBits = 32;
    localparam int DirBits   = 16;
    localparam int DirFrac   = 14;
    localparam int PathBits  = 40;
    localparam int EpsBits   = 16;
    // dividend |face - r| << 14 is at most 33 + 14 bits
    localparam int NumBits   = CoordBits + 1 + DirFrac;
    localparam int MagBits   = DirBits;
    localparam int DivCntBits = $clog2(NumBits + 1);
    localparam int CfgIdxBits = 3;
    localparam int InDataBits  = 3 * CoordBits + 3 * DirBits;
    localparam int OutDataBits = CoordBits + PathBits + 3 * CoordBits;

    localparam logic [CfgIdxBits-1:0] RegXMin = 3'd0;
    localparam logic [CfgIdxBits-1:0] RegXMax = 3'd1;
    localparam logic [CfgIdxBits-1:0] RegYMin = 3'd2;
    localparam logic [CfgIdxBits-1:0] RegYMax = 3'd3;
    localparam logic [CfgIdxBits-1:0] RegZMin = 3'd4;
    localparam logic [CfgIdxBits-1:0] RegZMax = 3'd5;
    localparam logic [CfgIdxBits-1:0] RegEps  = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SEG,
        ST_ADV0,
        ST_ADV1,
        ST_FACE,
        ST_FINAL,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ray_box_entry_clip.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ray_box_entry_clip
// Clips a ray origin onto the entry side of a config-held box, axis by axis,
// reporting each traveled segment and a final position or outside verdict.
// ---------------------------------------------------------------------------
//  channel  | dir | contents
//  s_axis   | in  | tuser new_path, tdata origin and direction
//  m_axis   | out | tuser is_final/outside/sat_flag, tlast last, tdata lengths, pos
//  cfg      | in  | register writes, index 0..6
//
//  per clipped axis the ray goes through a 47-step restoring divider (one
//  quotient bit a cycle), then the two advance multiplies and the face
//  update; each result waits in the output register until taken.
//  s_axis_tready is high only while idle. reset clears control state, box
//  faces to +-65536, inset to 1 and the path total to zero.
module ray_box_entry_clip (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // org_x, org_y, org_z, dir_x, dir_y, dir_z
    input  wire logic [rbec_pkg::InDataBits-1:0] s_axis_tdata,
    // new_path
    input  wire logic s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // seg_len, path_len, pos_x, pos_y, pos_z
    output logic [rbec_pkg::OutDataBits-1:0] m_axis_tdata,
    // is_final, outside, sat_flag
    output logic [2:0] m_axis_tuser,
    output logic       m_axis_tlast,
    input  wire logic  cfg_we,
    input  wire logic [rbec_pkg::CfgIdxBits-1:0] cfg_index,
    input  wire logic [rbec_pkg::CoordBits-1:0]  cfg_wdata
);
    import rbec_pkg::*;

    localparam int AdvBits  = DirBits + CoordBits - DirFrac + 1;
    localparam int WideBits = CoordBits + 3;

    localparam logic signed [CoordBits-1:0] CMax = {1'b0, {(CoordBits-1){1'b1}}};
    localparam logic signed [CoordBits-1:0] CMin = {1'b1, {(CoordBits-1){1'b0}}};
    localparam logic signed [WideBits-1:0] WideMax =
        {{(WideBits-CoordBits+1){1'b0}}, {(CoordBits-1){1'b1}}};
    localparam logic signed [WideBits-1:0] WideMin =
        {{(WideBits-CoordBits+1){1'b1}}, {(CoordBits-1){1'b0}}};
    localparam logic [PathBits-1:0] PMax = {PathBits{1'b1}};

    logic signed [CoordBits-1:0] face_reg [6];
    logic [EpsBits-1:0] eps_reg;
    logic [PathBits-1:0] path_reg, path_next;

    state_t state_reg, state_next;
    logic signed [CoordBits-1:0] r_reg [3];
    logic signed [CoordBits-1:0] r_next [3];
    logic signed [DirBits-1:0] k_reg [3];
    logic [1:0] axis_reg, axis_next;
    logic upper_reg, upper_next;
    logic signed [CoordBits-1:0] fsel_reg, fsel_next;
    logic anysat_reg, anysat_next;
    logic dsat_reg, dsat_next;
    logic [CoordBits-1:0] d_reg, d_next;
    logic [NumBits-1:0] num_reg, num_next;
    logic [NumBits-1:0] quo_reg, quo_next;
    logic [MagBits-1:0] rem_reg, rem_next;
    logic [MagBits-1:0] km_reg, km_next;
    logic [DivCntBits-1:0] cnt_reg, cnt_next;
    logic [1:0] adv_reg, adv_next;

    logic ov_reg, ov_next;
    logic [CoordBits-1:0] o_seg_reg, o_seg_next;
    logic [PathBits-1:0] o_path_reg, o_path_next;
    logic [CoordBits-1:0] o_pos_reg [3];
    logic [CoordBits-1:0] o_pos_next [3];
    logic [2:0] o_user_reg, o_user_next;
    logic o_last_reg, o_last_next;

    // shared signals
    logic signed [CoordBits-1:0] cur_r, lo_f, hi_f;
    logic signed [DirBits-1:0] cur_k;
    logic signed [CoordBits:0] diff;
    logic [CoordBits:0] diff_mag;
    logic [MagBits:0] rem_sh;
    logic [MagBits:0] rem_diff;
    logic [1:0] oth;
    logic signed [DirBits-1:0] ak;
    logic [DirBits-1:0] akm;
    logic [DirBits+CoordBits-1:0] prod;
    logic [AdvBits-1:0] adv_mag;
    logic signed [WideBits-1:0] r_wide, adv_wide, f_wide, e_wide;
    logic signed [WideBits-1:0] adv_sum;
    logic signed [WideBits-1:0] face_sum;
    logic [PathBits:0] psum;

    function automatic logic [1:0] other_axis(input logic [1:0] a, input logic [1:0] i);
        logic [1:0] res;
        res = 2'd0;
        case (a)
            2'd0:    res = (i == 2'd0) ? 2'd1 : 2'd2;
            2'd1:    res = (i == 2'd0) ? 2'd0 : 2'd2;
            default: res = (i == 2'd0) ? 2'd0 : 2'd1;
        endcase
        return res;
    endfunction

    assign s_axis_tready = aresetn && (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {o_pos_reg[2], o_pos_reg[1], o_pos_reg[0], o_path_reg, o_seg_reg};
    assign m_axis_tuser  = o_user_reg;
    assign m_axis_tlast  = o_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_reg[0] <= -32'sd65536;
            face_reg[1] <= 32'sd65536;
            face_reg[2] <= -32'sd65536;
            face_reg[3] <= 32'sd65536;
            face_reg[4] <= -32'sd65536;
            face_reg[5] <= 32'sd65536;
            eps_reg <= 16'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                RegXMin: face_reg[0] <= cfg_wdata;
                RegXMax: face_reg[1] <= cfg_wdata;
                RegYMin: face_reg[2] <= cfg_wdata;
                RegYMax: face_reg[3] <= cfg_wdata;
                RegZMin: face_reg[4] <= cfg_wdata;
                RegZMax: face_reg[5] <= cfg_wdata;
                RegEps:  eps_reg <= cfg_wdata[EpsBits-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            path_reg <= '0;
        end else begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            path_reg <= path_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            k_reg[0] <= s_axis_tdata[3*CoordBits +: DirBits];
            k_reg[1] <= s_axis_tdata[3*CoordBits+DirBits +: DirBits];
            k_reg[2] <= s_axis_tdata[3*CoordBits+2*DirBits +: DirBits];
        end
        for (int i = 0; i < 3; i++) begin
            r_reg[i] <= r_next[i];
            o_pos_reg[i] <= o_pos_next[i];
        end
        axis_reg <= axis_next;
        upper_reg <= upper_next;
        fsel_reg <= fsel_next;
        anysat_reg <= anysat_next;
        dsat_reg <= dsat_next;
        d_reg <= d_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        km_reg <= km_next;
        cnt_reg <= cnt_next;
        adv_reg <= adv_next;
        o_seg_reg <= o_seg_next;
        o_path_reg <= o_path_next;
        o_user_reg <= o_user_next;
        o_last_reg <= o_last_next;
    end

    always_comb begin
        state_next = state_reg;
        for (int i = 0; i < 3; i++) begin
            r_next[i] = r_reg[i];
            o_pos_next[i] = o_pos_reg[i];
        end
        axis_next = axis_reg;
        upper_next = upper_reg;
        fsel_next = fsel_reg;
        anysat_next = anysat_reg;
        dsat_next = dsat_reg;
        d_next = d_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        km_next = km_reg;
        cnt_next = cnt_reg;
        adv_next = adv_reg;
        ov_next = ov_reg;
        path_next = path_reg;
        o_seg_next = o_seg_reg;
        o_path_next = o_path_reg;
        o_user_next = o_user_reg;
        o_last_next = o_last_reg;

        if (m_axis_tready) ov_next = 1'b0;

        cur_r = r_reg[axis_reg];
        cur_k = k_reg[axis_reg];
        lo_f = face_reg[{axis_reg, 1'b0}];
        hi_f = face_reg[{axis_reg, 1'b1}];
        diff = (cur_r <= lo_f) ? ({lo_f[CoordBits-1], lo_f} - {cur_r[CoordBits-1], cur_r})
                               : ({cur_r[CoordBits-1], cur_r} - {hi_f[CoordBits-1], hi_f});
        diff_mag = diff;
        rem_sh = {rem_reg, num_reg[NumBits-1]};
        rem_diff = rem_sh - {1'b0, km_reg};
        oth = other_axis(axis_reg, adv_reg);
        ak = k_reg[oth];
        akm = ak[DirBits-1] ? (~ak + 1'b1) : ak;
        prod = akm * d_reg;
        adv_mag = AdvBits'(ak[DirBits-1]
            ? (({1'b0, prod} + ((DirBits+CoordBits+1)'(1) << DirFrac) - 1'b1) >> DirFrac)
            : ({1'b0, prod} >> DirFrac));
        r_wide = {{(WideBits-CoordBits){r_reg[oth][CoordBits-1]}}, r_reg[oth]};
        adv_wide = WideBits'(adv_mag);
        adv_sum = ak[DirBits-1] ? (r_wide - adv_wide) : (r_wide + adv_wide);
        f_wide = {{(WideBits-CoordBits){fsel_reg[CoordBits-1]}}, fsel_reg};
        e_wide = {{(WideBits-EpsBits){1'b0}}, eps_reg};
        face_sum = upper_reg ? (f_wide - e_wide) : (f_wide + e_wide);
        psum = {1'b0, path_reg} + (PathBits+1)'(d_reg);

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser) path_next = '0;
                    for (int i = 0; i < 3; i++)
                        r_next[i] = s_axis_tdata[i*CoordBits +: CoordBits];
                    axis_next = 2'd0;
                    anysat_next = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (axis_reg == 2'd3) begin
                    state_next = ST_FINAL;
                end else if (cur_r <= lo_f || cur_r >= hi_f) begin
                    upper_next = !(cur_r <= lo_f);
                    fsel_next = (cur_r <= lo_f) ? lo_f : hi_f;
                    if ((cur_r <= lo_f && cur_k <= 0) || (!(cur_r <= lo_f) && cur_k >= 0)) begin
                        state_next = ST_OUT;
                    end else begin
                        num_next = {diff_mag[CoordBits:0], {DirFrac{1'b0}}};
                        km_next = cur_k[DirBits-1] ? (~cur_k + 1'b1) : cur_k;
                        rem_next = '0;
                        quo_next = '0;
                        cnt_next = '0;
                        state_next = ST_DIV;
                    end
                end else begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            ST_DIV: begin
                // restoring divide, one quotient bit a cycle
                num_next = num_reg << 1;
                if (rem_sh >= {1'b0, km_reg}) begin
                    rem_next = rem_diff[MagBits-1:0];
                    quo_next = {quo_reg[NumBits-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[MagBits-1:0];
                    quo_next = {quo_reg[NumBits-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DivCntBits'(NumBits - 1)) state_next = ST_SEG;
            end
            ST_SEG: begin
                if (|quo_reg[NumBits-1:CoordBits]) begin
                    d_next = {CoordBits{1'b1}};
                    dsat_next = 1'b1;
                end else begin
                    d_next = quo_reg[CoordBits-1:0];
                    dsat_next = 1'b0;
                end
                adv_next = 2'd0;
                state_next = ST_ADV0;
            end
            ST_ADV0: begin
                if (adv_reg == 2'd0 && d_reg != '0) begin
                    // emit the segment record before the advance
                    if (!ov_reg || m_axis_tready) begin
                        if (psum[PathBits]) begin
                            path_next = PMax;
                            dsat_next = 1'b1;
                        end else begin
                            path_next = psum[PathBits-1:0];
                        end
                        o_seg_next = d_reg;
                        o_path_next = psum[PathBits] ? PMax : psum[PathBits-1:0];
                        for (int i = 0; i < 3; i++) o_pos_next[i] = '0;
                        o_user_next = {psum[PathBits] | dsat_reg, 1'b0, 1'b0};
                        o_last_next = 1'b0;
                        ov_next = 1'b1;
                        if (dsat_reg || psum[PathBits]) anysat_next = 1'b1;
                        state_next = ST_ADV1;
                    end
                end else begin
                    if (dsat_reg) anysat_next = 1'b1;
                    state_next = ST_ADV1;
                end
            end
            ST_ADV1: begin
                if (adv_sum > WideMax) begin
                    r_next[oth] = CMax;
                    anysat_next = 1'b1;
                end else if (adv_sum < WideMin) begin
                    r_next[oth] = CMin;
                    anysat_next = 1'b1;
                end else begin
                    r_next[oth] = adv_sum[CoordBits-1:0];
                end
                adv_next = adv_reg + 2'd1;
                if (adv_reg == 2'd1) state_next = ST_FACE;
            end
            ST_FACE: begin
                if (face_sum > WideMax) begin
                    r_next[axis_reg] = CMax;
                    anysat_next = 1'b1;
                end else if (face_sum < WideMin) begin
                    r_next[axis_reg] = CMin;
                    anysat_next = 1'b1;
                end else begin
                    r_next[axis_reg] = face_sum[CoordBits-1:0];
                end
                axis_next = axis_reg + 2'd1;
                state_next = ST_CHECK;
            end
            ST_FINAL, ST_OUT: begin
                if (!ov_reg || m_axis_tready) begin
                    o_seg_next = '0;
                    o_path_next = path_reg;
                    for (int i = 0; i < 3; i++)
                        o_pos_next[i] = (state_reg == ST_FINAL) ? r_reg[i] : '0;
                    o_user_next = {anysat_reg, state_reg == ST_OUT, 1'b1};
                    o_last_next = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire
